// ===== design/psr_pkg.sv =====
// shared constants and types for the point to segment radius test
// no dependencies
`default_nettype none

package psr_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 4;
    localparam int T_FRAC_BITS = 16;
    localparam int REACH_BITS  = 11;

    // clamp decision for the projection parameter
    typedef struct packed {
        logic zero;
        logic one;
    } tsel_t;

endpackage

`default_nettype wire

// ===== design/psr_if.sv =====
// item channel interfaces for the query and answer sides
// depends on psr_pkg
`default_nettype none

interface psr_query_if #(parameter int COORD_BITS = psr_pkg::COORD_BITS);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_BITS-1:0]      start_x;
    logic signed [COORD_BITS-1:0]      start_y;
    logic signed [COORD_BITS-1:0]      end_x;
    logic signed [COORD_BITS-1:0]      end_y;
    logic signed [COORD_BITS-1:0]      probe_x;
    logic signed [COORD_BITS-1:0]      probe_y;
    logic [psr_pkg::REACH_BITS-1:0]    reach;

    modport source (output valid, start_x, start_y, end_x, end_y, probe_x, probe_y, reach,
                    input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, probe_x, probe_y, reach,
                  output ready);
endinterface

interface psr_answer_if #(parameter int COORD_BITS = psr_pkg::COORD_BITS);
    logic                         valid;
    logic                         ready;
    logic                         touching;
    logic signed [COORD_BITS-1:0] closest_x;
    logic signed [COORD_BITS-1:0] closest_y;

    modport source (output valid, touching, closest_x, closest_y, input ready);
    modport sink (input valid, touching, closest_x, closest_y, output ready);
endinterface

`default_nettype wire

// ===== design/psr_prep.sv =====
// front stages: direction, dot products, squared length and clamp decision
// depends on psr_pkg
`default_nettype none

module psr_prep #(
    parameter int COORD_BITS = psr_pkg::COORD_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [COORD_BITS-1:0]      start_x,
    input  wire logic signed [COORD_BITS-1:0]      start_y,
    input  wire logic signed [COORD_BITS-1:0]      end_x,
    input  wire logic signed [COORD_BITS-1:0]      end_y,
    input  wire logic signed [COORD_BITS-1:0]      probe_x,
    input  wire logic signed [COORD_BITS-1:0]      probe_y,
    input  wire logic [psr_pkg::REACH_BITS-1:0]    reach,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [2*COORD_BITS:0]                  rem,
    output logic [2*COORD_BITS:0]                  den,
    output psr_pkg::tsel_t                         tsel,
    output logic [6*COORD_BITS+psr_pkg::REACH_BITS+1:0] pay
);

    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int DENW  = 2 * CW + 1;
    localparam int RESTW = 4 * CW + psr_pkg::REACH_BITS;

    logic                 a_v_reg;
    logic [RESTW-1:0]     a_rest_reg;
    logic signed [DW-1:0] a_dirx_reg, a_diry_reg, a_difx_reg, a_dify_reg;
    logic                 a_ready;

    logic                 b_v_reg;
    logic [RESTW-1:0]     b_rest_reg;
    logic signed [DW-1:0] b_dirx_reg, b_diry_reg;
    logic signed [PW-1:0] b_pnx_reg, b_pny_reg, b_pdx_reg, b_pdy_reg;
    logic                 b_ready;

    logic                  c_v_reg;
    logic [DENW-1:0]       c_rem_reg, c_den_reg;
    psr_pkg::tsel_t        c_tsel_reg;
    logic [RESTW+2*DW-1:0] c_pay_reg;
    logic                  c_ready;

    logic signed [DW-1:0] dirx_next, diry_next, difx_next, dify_next;
    logic signed [PW-1:0] num_next;
    logic [PW-1:0]        den_sum;
    logic [DENW-1:0]      den_next;
    psr_pkg::tsel_t       tsel_next;

    assign dirx_next = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
    assign diry_next = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
    assign difx_next = {probe_x[CW-1], probe_x} - {start_x[CW-1], start_x};
    assign dify_next = {probe_y[CW-1], probe_y} - {start_y[CW-1], start_y};

    assign c_ready  = !c_v_reg || out_ready;
    assign b_ready  = !b_v_reg || c_ready;
    assign a_ready  = !a_v_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_v_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_v_reg <= a_v_reg;
            end
            if (c_ready)
            begin
                c_v_reg <= b_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_rest_reg <= {start_x, start_y, probe_x, probe_y, reach};
            a_dirx_reg <= dirx_next;
            a_diry_reg <= diry_next;
            a_difx_reg <= difx_next;
            a_dify_reg <= dify_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_v_reg)
        begin
            b_rest_reg <= a_rest_reg;
            b_dirx_reg <= a_dirx_reg;
            b_diry_reg <= a_diry_reg;
            b_pnx_reg  <= a_difx_reg * a_dirx_reg;
            b_pny_reg  <= a_dify_reg * a_diry_reg;
            b_pdx_reg  <= a_dirx_reg * a_dirx_reg;
            b_pdy_reg  <= a_diry_reg * a_diry_reg;
        end
    end

    // zero-length segment gives num == 0, so it falls into the t = 0 case
    assign num_next = b_pnx_reg + b_pny_reg;
    assign den_sum  = b_pdx_reg + b_pdy_reg;
    assign den_next = den_sum[DENW-1:0];

    always_comb
    begin
        tsel_next.zero = (num_next[PW-1] || (num_next == '0));
        tsel_next.one  = !tsel_next.zero && (num_next[DENW-1:0] >= den_next);
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_v_reg)
        begin
            c_rem_reg  <= num_next[DENW-1:0];
            c_den_reg  <= den_next;
            c_tsel_reg <= tsel_next;
            c_pay_reg  <= {b_rest_reg, b_dirx_reg, b_diry_reg};
        end
    end

    assign out_valid = c_v_reg;
    assign rem       = c_rem_reg;
    assign den       = c_den_reg;
    assign tsel      = c_tsel_reg;
    assign pay       = c_pay_reg;

endmodule

`default_nettype wire

// ===== design/psr_div_cell.sv =====
// one restoring division cell: yields one quotient bit and passes the item on
// depends on psr_pkg
`default_nettype none

module psr_div_cell #(
    parameter int DENW = 2 * psr_pkg::COORD_BITS + 1,
    parameter int QW   = psr_pkg::T_FRAC_BITS,
    parameter int PAYW = 6 * psr_pkg::COORD_BITS + psr_pkg::REACH_BITS + 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [DENW-1:0]  in_rem,
    input  wire logic [DENW-1:0]  in_den,
    input  wire logic [QW-1:0]    in_q,
    input  wire psr_pkg::tsel_t   in_tsel,
    input  wire logic [PAYW-1:0]  in_pay,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [DENW-1:0]       out_rem,
    output logic [DENW-1:0]       out_den,
    output logic [QW-1:0]         out_q,
    output psr_pkg::tsel_t        out_tsel,
    output logic [PAYW-1:0]       out_pay
);

    logic              v_reg;
    logic [DENW-1:0]   rem_reg, den_reg;
    logic [QW-1:0]     q_reg;
    psr_pkg::tsel_t    tsel_reg;
    logic [PAYW-1:0]   pay_reg;

    logic [DENW:0]     rem2;
    logic [DENW:0]     diff;
    logic              ge;
    logic [DENW-1:0]   rem_next;

    assign rem2     = {in_rem, 1'b0};
    assign diff     = rem2 - {1'b0, in_den};
    assign ge       = (rem2 >= {1'b0, in_den});
    assign rem_next = ge ? diff[DENW-1:0] : rem2[DENW-1:0];

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            q_reg    <= {in_q[QW-2:0], ge};
            tsel_reg <= in_tsel;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_q     = q_reg;
    assign out_tsel  = tsel_reg;
    assign out_pay   = pay_reg;

endmodule

`default_nettype wire

// ===== design/psr_finish.sv =====
// back stages: closest point from t, squared distance and radius compare
// depends on psr_pkg
`default_nettype none

module psr_finish #(
    parameter int COORD_BITS  = psr_pkg::COORD_BITS,
    parameter int FRAC_BITS   = psr_pkg::FRAC_BITS,
    parameter int T_FRAC_BITS = psr_pkg::T_FRAC_BITS
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire logic [T_FRAC_BITS-1:0]                     q,
    input  wire psr_pkg::tsel_t                             tsel,
    input  wire logic [6*COORD_BITS+psr_pkg::REACH_BITS+1:0] pay,
    output logic                                            out_valid,
    input  wire logic                                       out_ready,
    output logic                                            touching,
    output logic signed [COORD_BITS-1:0]                    closest_x,
    output logic signed [COORD_BITS-1:0]                    closest_y
);

    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int RB    = psr_pkg::REACH_BITS;
    localparam int RESTW = 4 * CW + RB;
    localparam int TW    = T_FRAC_BITS + 1;
    localparam int PRW   = T_FRAC_BITS + CW + 3;
    localparam int SQW   = 2 * DW;
    localparam int RSW   = RB + FRAC_BITS;
    localparam int LIMW  = 2 * RSW;
    localparam int CMPW  = (SQW + 1 > LIMW) ? SQW + 1 : LIMW;
    localparam logic [PRW-1:0] HALF = {{(PRW-1){1'b0}}, 1'b1} << (T_FRAC_BITS - 1);
    localparam logic [TW-1:0]  T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    // stage d: t times direction
    logic                  d_v_reg, d_ready;
    logic [RESTW-1:0]      d_rest_reg;
    logic signed [PRW-1:0] d_prx_reg, d_pry_reg;

    // stage e: rounded closest point
    logic                  e_v_reg, e_ready;
    logic signed [CW-1:0]  e_px_reg, e_py_reg, e_cx_reg, e_cy_reg;
    logic [RB-1:0]         e_reach_reg;

    // stage f: squares
    logic                  f_v_reg, f_ready;
    logic signed [SQW-1:0] f_sqx_reg, f_sqy_reg;
    logic [LIMW-1:0]       f_lim_reg;
    logic signed [CW-1:0]  f_cx_reg, f_cy_reg;

    // stage g: output register
    logic                  g_v_reg, g_ready;
    logic                  g_touch_reg;
    logic signed [CW-1:0]  g_cx_reg, g_cy_reg;

    logic [RESTW-1:0]      in_rest;
    logic signed [DW-1:0]  in_dirx, in_diry;
    logic [TW-1:0]         t_val;
    logic signed [TW:0]    t_signed;

    logic signed [CW-1:0]  d_sx, d_sy, d_px, d_py;
    logic [RB-1:0]         d_reach;
    logic signed [PRW-1:0] rx, ry, shx, shy;
    logic signed [DW-1:0]  offx, offy, sumx, sumy;

    logic signed [DW-1:0]  dx, dy;
    logic [RSW-1:0]        rs;

    logic [SQW:0]          dist_sum;
    logic [CMPW-1:0]       dist_ext, lim_ext;

    assign g_ready  = !g_v_reg || out_ready;
    assign f_ready  = !f_v_reg || g_ready;
    assign e_ready  = !e_v_reg || f_ready;
    assign d_ready  = !d_v_reg || e_ready;
    assign in_ready = d_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
            begin
                d_v_reg <= in_valid;
            end
            if (e_ready)
            begin
                e_v_reg <= d_v_reg;
            end
            if (f_ready)
            begin
                f_v_reg <= e_v_reg;
            end
            if (g_ready)
            begin
                g_v_reg <= f_v_reg;
            end
        end
    end

    assign {in_rest, in_dirx, in_diry} = pay;

    always_comb
    begin
        if (tsel.one)
        begin
            t_val = T_ONE;
        end
        else if (tsel.zero)
        begin
            t_val = '0;
        end
        else
        begin
            t_val = {1'b0, q};
        end
    end

    assign t_signed = {1'b0, t_val};

    always_ff @(posedge clk)
    begin
        if (d_ready && in_valid)
        begin
            d_rest_reg <= in_rest;
            d_prx_reg  <= t_signed * in_dirx;
            d_pry_reg  <= t_signed * in_diry;
        end
    end

    // round to nearest, ties toward plus infinity
    assign {d_sx, d_sy, d_px, d_py, d_reach} = d_rest_reg;
    assign rx   = d_prx_reg + $signed(HALF);
    assign ry   = d_pry_reg + $signed(HALF);
    assign shx  = rx >>> T_FRAC_BITS;
    assign shy  = ry >>> T_FRAC_BITS;
    assign offx = shx[DW-1:0];
    assign offy = shy[DW-1:0];
    assign sumx = {d_sx[CW-1], d_sx} + offx;
    assign sumy = {d_sy[CW-1], d_sy} + offy;

    always_ff @(posedge clk)
    begin
        if (e_ready && d_v_reg)
        begin
            e_px_reg    <= d_px;
            e_py_reg    <= d_py;
            e_cx_reg    <= sumx[CW-1:0];
            e_cy_reg    <= sumy[CW-1:0];
            e_reach_reg <= d_reach;
        end
    end

    assign dx = {e_px_reg[CW-1], e_px_reg} - {e_cx_reg[CW-1], e_cx_reg};
    assign dy = {e_py_reg[CW-1], e_py_reg} - {e_cy_reg[CW-1], e_cy_reg};
    assign rs = RSW'(e_reach_reg) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (f_ready && e_v_reg)
        begin
            f_sqx_reg <= dx * dx;
            f_sqy_reg <= dy * dy;
            f_lim_reg <= rs * rs;
            f_cx_reg  <= e_cx_reg;
            f_cy_reg  <= e_cy_reg;
        end
    end

    assign dist_sum = {1'b0, f_sqx_reg} + {1'b0, f_sqy_reg};
    assign dist_ext = CMPW'(dist_sum);
    assign lim_ext  = CMPW'(f_lim_reg);

    always_ff @(posedge clk)
    begin
        if (g_ready && f_v_reg)
        begin
            g_touch_reg <= (dist_ext <= lim_ext);
            g_cx_reg    <= f_cx_reg;
            g_cy_reg    <= f_cy_reg;
        end
    end

    assign out_valid = g_v_reg;
    assign touching  = g_touch_reg;
    assign closest_x = g_cx_reg;
    assign closest_y = g_cy_reg;

endmodule

`default_nettype wire

// ===== design/point_segment_radius_test.sv =====
// top level of the point to segment radius test
// depends on psr_pkg, psr_if, psr_prep, psr_div_cell and psr_finish
`default_nettype none

// Takes one query item per clock while query.ready is high and returns one answer
// item per query, in order. Three front stages form the dot products and the clamp
// decision, a chain of T_FRAC_BITS restoring division cells produces one bit of t
// each, and four back stages turn t into the rounded closest point and the radius
// compare. Every stage holds one item, and a stage with no item passes its input on,
// so gaps close up behind a stalled answer side and the query side stays open until
// the whole chain is full.

module point_segment_radius_test #(
    parameter int COORD_BITS  = psr_pkg::COORD_BITS,
    parameter int FRAC_BITS   = psr_pkg::FRAC_BITS,
    parameter int T_FRAC_BITS = psr_pkg::T_FRAC_BITS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    psr_query_if.sink      query,
    psr_answer_if.source   answer
);

    localparam int DENW = 2 * COORD_BITS + 1;
    localparam int PAYW = 6 * COORD_BITS + psr_pkg::REACH_BITS + 2;
    localparam int NC   = T_FRAC_BITS;

    logic                   div_valid [0:NC];
    logic                   div_ready [0:NC];
    logic [DENW-1:0]        div_rem   [0:NC];
    logic [DENW-1:0]        div_den   [0:NC];
    logic [T_FRAC_BITS-1:0] div_q     [0:NC];
    psr_pkg::tsel_t         div_tsel  [0:NC];
    logic [PAYW-1:0]        div_pay   [0:NC];

    psr_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query.valid),
        .in_ready  (query.ready),
        .start_x   (query.start_x),
        .start_y   (query.start_y),
        .end_x     (query.end_x),
        .end_y     (query.end_y),
        .probe_x   (query.probe_x),
        .probe_y   (query.probe_y),
        .reach     (query.reach),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .rem       (div_rem[0]),
        .den       (div_den[0]),
        .tsel      (div_tsel[0]),
        .pay       (div_pay[0])
    );

    assign div_q[0] = '0;

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        psr_div_cell #(
            .DENW (DENW),
            .QW   (T_FRAC_BITS),
            .PAYW (PAYW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_rem    (div_rem[k]),
            .in_den    (div_den[k]),
            .in_q      (div_q[k]),
            .in_tsel   (div_tsel[k]),
            .in_pay    (div_pay[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_rem   (div_rem[k+1]),
            .out_den   (div_den[k+1]),
            .out_q     (div_q[k+1]),
            .out_tsel  (div_tsel[k+1]),
            .out_pay   (div_pay[k+1])
        );
    end

    psr_finish #(
        .COORD_BITS  (COORD_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[NC]),
        .in_ready  (div_ready[NC]),
        .q         (div_q[NC]),
        .tsel      (div_tsel[NC]),
        .pay       (div_pay[NC]),
        .out_valid (answer.valid),
        .out_ready (answer.ready),
        .touching  (answer.touching),
        .closest_x (answer.closest_x),
        .closest_y (answer.closest_y)
    );

`ifndef SYNTH
    a_tsel_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid[0] |-> !(div_tsel[0].zero && div_tsel[0].one))
        else $error("clamp decision marks both ends");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid[NC] && !div_tsel[NC].zero && !div_tsel[NC].one)
        |-> (div_rem[NC] < div_den[NC]))
        else $error("division remainder not below divisor");

    a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !query.ready |-> (answer.valid && !answer.ready))
        else $error("query side closed while answer side is free");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for point_segment_radius_test: directed table, then random items
// compares every answer item by field with a typed row or a fixed-point predictor
// depends on psr_pkg, psr_if and the design sources
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS    = psr_pkg::COORD_BITS;
    localparam int FRAC_BITS     = psr_pkg::FRAC_BITS;
    localparam int T_FRAC_BITS   = psr_pkg::T_FRAC_BITS;
    localparam int REACH_BITS    = psr_pkg::REACH_BITS;

    localparam int RANDOM_ITEMS  = 1830;
    localparam int CALM_ITEMS    = 200;
    localparam int HOLD_CYCLES   = 120;
    localparam int HOLD_AFTER    = 500;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = T_FRAC_BITS + 12;
    localparam int REPORT_LIMIT  = 100;
    localparam int MAX_COORD     = (1 << (COORD_BITS - 1)) - 1;
    localparam int MIN_COORD     = -(1 << (COORD_BITS - 1));

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] probe_x;
        logic signed [COORD_BITS-1:0] probe_y;
        logic [REACH_BITS-1:0]        reach;
    } query_t;

    typedef struct packed {
        logic                         touching;
        logic signed [COORD_BITS-1:0] closest_x;
        logic signed [COORD_BITS-1:0] closest_y;
    } answer_t;

    typedef struct packed {
        query_t  q;
        logic    typed;
        answer_t a;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n;

    psr_query_if  query_ch ();
    psr_answer_if answer_ch ();

    point_segment_radius_test dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .answer (answer_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    answer_t    expected_answers[$];
    table_row_t directed_rows[$];
    int         queries_sent = 0;
    int         answers_checked = 0;
    int         touching_seen = 0;
    int         mismatches = 0;
    int         idle_cycles = 0;
    bit         calm = 1'b0;
    bit         backlog_done = 1'b0;

    function automatic answer_t nearest_on_segment(input query_t q);
        longint sx, sy, ex, ey, px, py;
        longint dirx, diry, num, den, t, cx, cy, dx, dy, dist_sq, rs, lim, half;
        answer_t a;
        sx = longint'(q.start_x);
        sy = longint'(q.start_y);
        ex = longint'(q.end_x);
        ey = longint'(q.end_y);
        px = longint'(q.probe_x);
        py = longint'(q.probe_y);
        dirx = ex - sx;
        diry = ey - sy;
        cx = sx;
        cy = sy;
        if (dirx != 0 || diry != 0)
        begin
            num = (px - sx) * dirx + (py - sy) * diry;
            den = dirx * dirx + diry * diry;
            if (num <= 0)
                t = 0;
            else if (num >= den)
                t = longint'(1) <<< T_FRAC_BITS;
            else
                t = (num <<< T_FRAC_BITS) / den;
            half = longint'(1) <<< (T_FRAC_BITS - 1);
            cx = sx + ((t * dirx + half) >>> T_FRAC_BITS);
            cy = sy + ((t * diry + half) >>> T_FRAC_BITS);
        end
        dx = px - cx;
        dy = py - cy;
        dist_sq = dx * dx + dy * dy;
        rs = longint'(q.reach) <<< FRAC_BITS;
        lim = rs * rs;
        a.touching = (dist_sq <= lim);
        a.closest_x = cx[COORD_BITS-1:0];
        a.closest_y = cy[COORD_BITS-1:0];
        return a;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] corner_coord();
        case ($urandom_range(0, 5))
            0: return COORD_BITS'(MIN_COORD);
            1: return COORD_BITS'(MAX_COORD);
            2: return '0;
            3: return '1;
            4: return COORD_BITS'(1);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic query_t random_query();
        query_t q;
        int bx, by, mode, k;
        mode = $urandom_range(0, 99);
        q = '0;
        q.start_x = COORD_BITS'($urandom);
        q.start_y = COORD_BITS'($urandom);
        q.end_x = COORD_BITS'($urandom);
        q.end_y = COORD_BITS'($urandom);
        q.probe_x = COORD_BITS'($urandom);
        q.probe_y = COORD_BITS'($urandom);
        q.reach = REACH_BITS'($urandom);
        if (mode < 15)
        begin
            q.end_x = q.start_x;
            q.end_y = q.start_y;
            if (mode < 10)
            begin
                q.probe_x = COORD_BITS'(q.start_x + (int'($urandom_range(0, 511)) - 256));
                q.probe_y = COORD_BITS'(q.start_y + (int'($urandom_range(0, 511)) - 256));
                q.reach = REACH_BITS'($urandom_range(0, 24));
            end
        end
        else if (mode < 30)
        begin
            q.start_x = corner_coord();
            q.start_y = corner_coord();
            q.end_x = corner_coord();
            q.end_y = corner_coord();
            q.probe_x = corner_coord();
            q.probe_y = corner_coord();
            q.reach = ($urandom_range(0, 1) != 0) ? 11'h7ff : 11'($urandom);
        end
        else if (mode < 50)
        begin
            // full-range item, fields already random
        end
        else
        begin
            bx = int'($urandom_range(0, 60000)) - 30000;
            by = int'($urandom_range(0, 60000)) - 30000;
            q.start_x = COORD_BITS'(bx + int'($urandom_range(0, 4095)) - 2048);
            q.start_y = COORD_BITS'(by + int'($urandom_range(0, 4095)) - 2048);
            q.end_x = COORD_BITS'(bx + int'($urandom_range(0, 4095)) - 2048);
            q.end_y = COORD_BITS'(by + int'($urandom_range(0, 4095)) - 2048);
            if (mode < 60)
            begin
                k = $urandom_range(0, 8);
                q.probe_x = COORD_BITS'(q.start_x +
                                        ((int'(q.end_x) - int'(q.start_x)) * k) / 8);
                q.probe_y = COORD_BITS'(q.start_y +
                                        ((int'(q.end_y) - int'(q.start_y)) * k) / 8);
            end
            else
            begin
                q.probe_x = COORD_BITS'(bx + int'($urandom_range(0, 4095)) - 2048);
                q.probe_y = COORD_BITS'(by + int'($urandom_range(0, 4095)) - 2048);
            end
            q.reach = REACH_BITS'($urandom_range(0, 160));
        end
        return q;
    endfunction

    task automatic add_row(input int sx, input int sy, input int ex, input int ey,
                           input int px, input int py, input int r, input bit typed,
                           input bit touch, input int cx, input int cy);
        table_row_t row;
        row.q.start_x = COORD_BITS'(sx);
        row.q.start_y = COORD_BITS'(sy);
        row.q.end_x = COORD_BITS'(ex);
        row.q.end_y = COORD_BITS'(ey);
        row.q.probe_x = COORD_BITS'(px);
        row.q.probe_y = COORD_BITS'(py);
        row.q.reach = REACH_BITS'(r);
        row.typed = typed;
        row.a.touching = touch;
        row.a.closest_x = COORD_BITS'(cx);
        row.a.closest_y = COORD_BITS'(cy);
        directed_rows = {directed_rows, row};
    endtask

    task automatic send_query(input query_t q, input bit typed, input answer_t want);
        answer_t due;
        query_ch.valid <= 1'b1;
        query_ch.start_x <= q.start_x;
        query_ch.start_y <= q.start_y;
        query_ch.end_x <= q.end_x;
        query_ch.end_y <= q.end_y;
        query_ch.probe_x <= q.probe_x;
        query_ch.probe_y <= q.probe_y;
        query_ch.reach <= q.reach;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
        due = typed ? want : nearest_on_segment(q);
        expected_answers = {expected_answers, due};
        queries_sent++;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            query_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        query_ch.valid <= 1'b0;
        query_ch.start_x <= '0;
        query_ch.start_y <= '0;
        query_ch.end_x <= '0;
        query_ch.end_y <= '0;
        query_ch.probe_x <= '0;
        query_ch.probe_y <= '0;
        query_ch.reach <= '0;
        answer_ch.ready <= 1'b0;

        // zero-length segments, clamps at both ends, rounding ties, corners
        add_row(0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        add_row(MIN_COORD, MAX_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MIN_COORD, 2047,
                1, 0, MIN_COORD, MAX_COORD);
        add_row(MAX_COORD, MIN_COORD, MAX_COORD, MIN_COORD, MIN_COORD, MAX_COORD, 0,
                1, 0, MAX_COORD, MIN_COORD);
        add_row(-5, -7, -5, -7, -5, -7, 1024, 1, 1, -5, -7);
        add_row(0, 0, 160, 0, -16, 0, 1, 1, 1, 0, 0);
        add_row(300, 300, -300, -300, 400, 400, 1, 1, 0, 300, 300);
        add_row(0, 0, 160, 0, 320, 0, 0, 1, 0, 160, 0);
        add_row(0, 0, 16, 0, 1000, -5, 2047, 1, 1, 16, 0);
        add_row(100, 200, 100, 520, 100, 200, 0, 1, 1, 100, 200);
        add_row(100, 200, 100, 520, 100, 600, 5, 1, 1, 100, 520);
        add_row(100, 200, 100, 520, 100, 600, 4, 1, 0, 100, 520);
        add_row(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MAX_COORD, MIN_COORD, 2047,
                0, 0, 0, 0);
        add_row(MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD, 0, 0, 2047, 0, 0, 0, 0);
        add_row(MIN_COORD, 0, MAX_COORD, 0, 0, MAX_COORD, 2047, 0, 0, 0, 0);
        add_row(0, 0, 0, MIN_COORD, MAX_COORD, -16384, 2047, 0, 0, 0, 0);
        add_row(0, 0, 32, 0, 16, 16, 1, 0, 0, 0, 0);
        add_row(0, 0, -32, 0, -16, 16, 1, 0, 0, 0, 0);
        add_row(0, 0, 1, 0, 0, 5, 0, 0, 0, 0, 0);
        add_row(0, 0, -1, 0, 0, 5, 0, 0, 0, 0, 0);
        add_row(1000, -1000, -1000, 1000, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 48, 16, 7, 33, 2, 0, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_query(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].a);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_query(random_query(), 1'b0, '0);
        end
        query_ch.valid <= 1'b0;

        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_answers.size() != 0)
            mismatches++;
        $display("sent %0d query items (%0d directed), checked %0d answer items",
                 queries_sent, directed_rows.size(), answers_checked);
        $display("%0d answers touching, long answer-side hold-off done: %0d",
                 touching_seen, backlog_done);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        answer_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!backlog_done && answers_checked >= HOLD_AFTER)
            begin
                answer_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                answer_ch.ready <= 1'b1;
                backlog_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                answer_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                answer_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && answer_ch.valid && answer_ch.ready)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected answer item touching %0d closest %0d,%0d",
                             $time, answer_ch.touching, answer_ch.closest_x,
                             answer_ch.closest_y);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (answer_ch.touching !== want.touching)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: item %0d touching expected %0d actual %0d",
                                 $time, answers_checked, want.touching, answer_ch.touching);
                end
                if (answer_ch.closest_x !== want.closest_x)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: item %0d closest_x expected %0d actual %0d",
                                 $time, answers_checked, want.closest_x, answer_ch.closest_x);
                end
                if (answer_ch.closest_y !== want.closest_y)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: item %0d closest_y expected %0d actual %0d",
                                 $time, answers_checked, want.closest_y, answer_ch.closest_y);
                end
                if (want.touching)
                    touching_seen++;
            end
            answers_checked++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (query_ch.valid && query_ch.ready) ||
            (answer_ch.valid && answer_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("testbench failed");
            $finish;
        end
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/psr_pkg.sv
design/psr_if.sv
design/psr_prep.sv
design/psr_div_cell.sv
design/psr_finish.sv
design/point_segment_radius_test.sv
dv/testbench.sv
